>>> rtl/assert_macros.svh
// Assertion macros used by the directory search RTL.
// Stand-alone header; define NO_ASSERTIONS to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/fdes_pkg.sv
// Types and constants of the FAT directory entry search.
// No dependencies.
package fdes_pkg;

    localparam logic [7:0] ENTRY_DELETED = 8'hE5;
    localparam logic [7:0] ENTRY_END     = 8'h00;
    localparam logic [7:0] ATTR_LONGNAME = 8'h0F;
    localparam logic [7:0] ATTR_LABEL    = 8'h08;

    localparam logic [1:0] REG_NAME_MAIN = 2'd0;
    localparam logic [1:0] REG_NAME_EXT  = 2'd1;
    localparam logic [1:0] REG_SLOT_MODE = 2'd2;

    typedef enum logic [1:0] {
        ST_EXISTING  = 2'd0,
        ST_FRESH     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic        found;
        logic        have_slot;
        logic        want_slot;
        logic [31:0] sector;
        logic [3:0]  index;
        logic [31:0] cluster;
    } cmd_t;

endpackage

>>> rtl/fdes_front.sv
// Front end: classifies each directory word and tracks the search state.
// Depends on fdes_pkg.
module fdes_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [63:0]        name_main,
    input  logic [23:0]        name_ext,
    input  logic [7:0]         attributes,
    input  logic [15:0]        cluster_high,
    input  logic [15:0]        cluster_low,
    input  logic [31:0]        sector_address,
    input  logic [3:0]         entry_index,
    input  logic               start_search,
    input  logic               chain_end,
    input  logic [63:0]        wanted_main,
    input  logic [23:0]        wanted_ext,
    input  logic               want_slot,
    output logic               push,
    output fdes_pkg::cmd_t     cmd
);

    logic        done_reg, done_next;
    logic        have_reg, have_next;
    logic [31:0] free_sector_reg, free_sector_next;
    logic [3:0]  free_index_reg, free_index_next;

    logic        cur_done, cur_have;
    logic        is_end, is_deleted, is_skip, is_match;
    logic        finish, hit;

    always_comb begin
        cur_done   = start_search ? 1'b0 : done_reg;
        cur_have   = start_search ? 1'b0 : have_reg;
        is_end     = name_main[7:0] == fdes_pkg::ENTRY_END;
        is_deleted = name_main[7:0] == fdes_pkg::ENTRY_DELETED;
        is_skip    = (attributes == fdes_pkg::ATTR_LONGNAME) ||
                     ((attributes & fdes_pkg::ATTR_LABEL) != 8'h00);
        is_match   = (name_main == wanted_main) && (name_ext == wanted_ext);

        done_next        = cur_done;
        have_next        = cur_have;
        free_sector_next = free_sector_reg;
        free_index_next  = free_index_reg;
        finish           = 1'b0;
        hit              = 1'b0;

        if (!cur_done) begin
            if (is_end || is_deleted) begin
                if (!cur_have) begin
                    have_next        = 1'b1;
                    free_sector_next = sector_address;
                    free_index_next  = entry_index;
                end
                finish = is_end || chain_end;
            end else if (is_skip) begin
                finish = chain_end;
            end else if (is_match) begin
                hit = 1'b1;
            end else begin
                finish = chain_end;
            end
        end
        if (finish || hit) begin
            done_next = 1'b1;
        end

        push          = accept && (finish || hit);
        cmd.found     = hit;
        cmd.have_slot = have_next;
        cmd.want_slot = want_slot;
        cmd.sector    = hit ? sector_address : free_sector_next;
        cmd.index     = hit ? entry_index : free_index_next;
        cmd.cluster   = {cluster_high, cluster_low};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
            have_reg <= 1'b0;
        end else if (accept) begin
            done_reg <= done_next;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            free_sector_reg <= free_sector_next;
            free_index_reg  <= free_index_next;
        end
    end

endmodule

>>> rtl/fdes_queue.sv
// Short result queue between the front end and the output stage.
// Depends on fdes_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fdes_queue #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fdes_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output fdes_pkg::cmd_t head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fdes_pkg::cmd_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slots_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && full && !pop)
    `ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && !head_valid)
    `ASSERT_PROP(a_cnt_up, aclk, aresetn, (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)

endmodule

>>> rtl/fdes_back.sv
// Output stage: turns queued decisions into result words and holds them.
// Depends on fdes_pkg.
module fdes_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  fdes_pkg::cmd_t head_data,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic [31:0]    m_slot_sector,
    output logic [8:0]     m_slot_offset,
    output logic [31:0]    m_start_cluster
);

    logic                m_valid_reg;
    fdes_pkg::status_t   status_next;
    logic                give_slot;

    assign pop     = head_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        give_slot = head_data.found || (head_data.want_slot && head_data.have_slot);
        if (head_data.found) begin
            status_next = fdes_pkg::ST_EXISTING;
        end else if (!head_data.want_slot) begin
            status_next = fdes_pkg::ST_NOT_FOUND;
        end else if (head_data.have_slot) begin
            status_next = fdes_pkg::ST_FRESH;
        end else begin
            status_next = fdes_pkg::ST_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_status        <= status_next;
            m_slot_sector   <= give_slot ? head_data.sector : 32'h0;
            m_slot_offset   <= give_slot ? {head_data.index, 5'b00000} : 9'h000;
            m_start_cluster <= head_data.found ? head_data.cluster : 32'h0;
        end
    end

endmodule

>>> rtl/fat_directory_entry_search.sv
// Top level of the FAT directory entry search: register port, front end,
// result queue and output stage. Depends on fdes_pkg and the fdes_* modules.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    one directory entry word
//  m_       out        m_valid/m_ready    one search result word
//  apb      in         psel/penable       name and mode registers
//
// One entry is accepted per cycle while s_ready is high; the name compare is
// combinational and the state update is registered in the front end. The result
// of the entry ending the search is written to the result queue and then to the
// output register, which raises m_valid. s_ready drops only when QUEUE_DEPTH
// results wait behind a stalled output register. Reset is synchronous; there is no clearing pass.
module fat_directory_entry_search #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_name_main,
    input  logic [23:0] s_name_ext,
    input  logic [7:0]  s_attributes,
    input  logic [15:0] s_cluster_high,
    input  logic [15:0] s_cluster_low,
    input  logic [31:0] s_sector_address,
    input  logic [3:0]  s_entry_index,
    input  logic        s_start_search,
    input  logic        s_chain_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_slot_sector,
    output logic [8:0]  m_slot_offset,
    output logic [31:0] m_start_cluster
);

    logic [63:0]    wanted_main_reg;
    logic [23:0]    wanted_ext_reg;
    logic           want_slot_reg;
    logic           cfg_write;
    logic           queue_full, push, pop, head_valid;
    fdes_pkg::cmd_t cmd, head_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_ready   = !queue_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_main_reg <= '0;
            wanted_ext_reg  <= '0;
            want_slot_reg   <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[4:3])
                fdes_pkg::REG_NAME_MAIN: wanted_main_reg <= pwdata;
                fdes_pkg::REG_NAME_EXT:  wanted_ext_reg  <= pwdata[23:0];
                fdes_pkg::REG_SLOT_MODE: want_slot_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            fdes_pkg::REG_NAME_MAIN: prdata = wanted_main_reg;
            fdes_pkg::REG_NAME_EXT:  prdata = {40'h0, wanted_ext_reg};
            fdes_pkg::REG_SLOT_MODE: prdata = {63'h0, want_slot_reg};
            default:                 prdata = 64'h0;
        endcase
    end

    fdes_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_valid && s_ready),
        .name_main      (s_name_main),
        .name_ext       (s_name_ext),
        .attributes     (s_attributes),
        .cluster_high   (s_cluster_high),
        .cluster_low    (s_cluster_low),
        .sector_address (s_sector_address),
        .entry_index    (s_entry_index),
        .start_search   (s_start_search),
        .chain_end      (s_chain_end),
        .wanted_main    (wanted_main_reg),
        .wanted_ext     (wanted_ext_reg),
        .want_slot      (want_slot_reg),
        .push           (push),
        .cmd            (cmd)
    );

    fdes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    fdes_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_data       (head_data),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot_sector   (m_slot_sector),
        .m_slot_offset   (m_slot_offset),
        .m_start_cluster (m_start_cluster)
    );

endmodule

>>> test/tb_top.sv
// Self-checking testbench for fat_directory_entry_search: directed and random directory
// scans over the stream port, checked word by word against an in-bench search model.
// Depends on fdes_pkg and the fat_directory_entry_search RTL; reads no files.
module tb_top;

    typedef struct packed {
        logic [63:0] name_main;
        logic [23:0] name_ext;
        logic [7:0]  attributes;
        logic [15:0] cluster_high;
        logic [15:0] cluster_low;
        logic [31:0] sector_address;
        logic [3:0]  entry_index;
        logic        start_search;
        logic        chain_end;
    } dir_entry_t;

    typedef struct packed {
        fdes_pkg::status_t status;
        logic [31:0]       slot_sector;
        logic [8:0]        slot_offset;
        logic [31:0]       start_cluster;
    } lookup_result_t;

    typedef enum int {
        KIND_LIVE, KIND_MATCH, KIND_NEAR, KIND_DELETED, KIND_END, KIND_LONGNAME, KIND_LABEL
    } entry_kind_t;

    localparam logic [63:0] README_MAIN = 64'h2020_454D_4441_4552;
    localparam logic [23:0] README_EXT  = 24'h54_58_54;
    localparam logic [63:0] OTHER_MAIN  = README_MAIN ^ 64'h0000_0000_0000_0100;
    localparam logic [63:0] ERASED_MAIN = {README_MAIN[63:8], fdes_pkg::ENTRY_DELETED};
    localparam logic [63:0] MARKER_MAIN = {README_MAIN[63:8], fdes_pkg::ENTRY_END};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_name_main = '0;
    logic [23:0] s_name_ext = '0;
    logic [7:0]  s_attributes = '0;
    logic [15:0] s_cluster_high = '0;
    logic [15:0] s_cluster_low = '0;
    logic [31:0] s_sector_address = '0;
    logic [3:0]  s_entry_index = '0;
    logic        s_start_search = 1'b0;
    logic        s_chain_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_slot_sector;
    logic [8:0]  m_slot_offset;
    logic [31:0] m_start_cluster;

    logic [63:0] want_main = '0;
    logic [23:0] want_ext = '0;
    logic        fresh_on_miss = 1'b0;
    logic        scan_finished = 1'b0;
    logic        slot_held = 1'b0;
    logic [31:0] held_sector = '0;
    logic [3:0]  held_index = '0;

    lookup_result_t pending_lookups[$];
    lookup_result_t oldest;
    bit src_idle_on = 1'b1;
    bit dst_idle_on = 1'b1;
    int entries_sent = 0;
    int entries_considered = 0;
    int register_writes = 0;
    int mismatches = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    fat_directory_entry_search dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_name_main(s_name_main), .s_name_ext(s_name_ext), .s_attributes(s_attributes),
        .s_cluster_high(s_cluster_high), .s_cluster_low(s_cluster_low),
        .s_sector_address(s_sector_address), .s_entry_index(s_entry_index),
        .s_start_search(s_start_search), .s_chain_end(s_chain_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_slot_sector(m_slot_sector),
        .m_slot_offset(m_slot_offset), .m_start_cluster(m_start_cluster)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int draw_gap(inout bit idle_on);
        if ($urandom_range(0, 39) == 0)
            idle_on = !idle_on;
        return idle_on ? $urandom_range(0, 17) : 0;
    endfunction

    function automatic lookup_result_t close_search();
        lookup_result_t r;
        r = '0;
        scan_finished = 1'b1;
        if (!fresh_on_miss) begin
            r.status = fdes_pkg::ST_NOT_FOUND;
        end else if (slot_held) begin
            r.status = fdes_pkg::ST_FRESH;
            r.slot_sector = held_sector;
            r.slot_offset = {held_index, 5'b00000};
        end else begin
            r.status = fdes_pkg::ST_FULL;
        end
        return r;
    endfunction

    function automatic bit step_search(input dir_entry_t e, output lookup_result_t r);
        logic [7:0] lead;
        lead = e.name_main[7:0];
        r = '0;
        if (e.start_search) begin
            scan_finished = 1'b0;
            slot_held = 1'b0;
            held_sector = '0;
            held_index = '0;
        end
        if (scan_finished)
            return 1'b0;
        entries_considered++;
        if (lead == fdes_pkg::ENTRY_END || lead == fdes_pkg::ENTRY_DELETED) begin
            if (!slot_held) begin
                slot_held = 1'b1;
                held_sector = e.sector_address;
                held_index = e.entry_index;
            end
        end else if (e.attributes != fdes_pkg::ATTR_LONGNAME
                     && (e.attributes & fdes_pkg::ATTR_LABEL) == 8'h00
                     && e.name_main == want_main && e.name_ext == want_ext) begin
            scan_finished = 1'b1;
            r.status = fdes_pkg::ST_EXISTING;
            r.slot_sector = e.sector_address;
            r.slot_offset = {e.entry_index, 5'b00000};
            r.start_cluster = {e.cluster_high, e.cluster_low};
            return 1'b1;
        end
        if (lead == fdes_pkg::ENTRY_END || e.chain_end) begin
            r = close_search();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic dir_entry_t entry_of(input logic [63:0] main, input logic [23:0] ext,
                                            input logic [7:0] attr, input logic [31:0] sector,
                                            input logic [3:0] slot, input bit is_start,
                                            input bit is_last);
        dir_entry_t e;
        e.name_main = main;
        e.name_ext = ext;
        e.attributes = attr;
        e.cluster_high = 16'($urandom);
        e.cluster_low = 16'($urandom);
        e.sector_address = sector;
        e.entry_index = slot;
        e.start_search = is_start;
        e.chain_end = is_last;
        return e;
    endfunction

    function automatic dir_entry_t shape_entry(input entry_kind_t kind);
        dir_entry_t e;
        int flip;
        e = entry_of({$urandom, $urandom}, 24'($urandom), 8'($urandom), $urandom,
                     4'($urandom), 1'b0, 1'b0);
        case (kind)
            KIND_LIVE: begin
                if (e.name_main[7:0] == fdes_pkg::ENTRY_END ||
                    e.name_main[7:0] == fdes_pkg::ENTRY_DELETED)
                    e.name_main[0] = ~e.name_main[0];
                e.attributes[3] = 1'b0;
            end
            KIND_MATCH: begin
                e.name_main = want_main;
                e.name_ext = want_ext;
                e.attributes[3] = 1'b0;
            end
            KIND_NEAR: begin
                e.name_main = want_main;
                e.name_ext = want_ext;
                e.attributes[3] = 1'b0;
                flip = $urandom_range(0, 87);
                if (flip < 64)
                    e.name_main[flip] = ~e.name_main[flip];
                else
                    e.name_ext[flip - 64] = ~e.name_ext[flip - 64];
            end
            KIND_DELETED: e.name_main[7:0] = fdes_pkg::ENTRY_DELETED;
            KIND_END: e.name_main[7:0] = fdes_pkg::ENTRY_END;
            KIND_LONGNAME: begin
                e.attributes = fdes_pkg::ATTR_LONGNAME;
                if ($urandom_range(0, 1) != 0) begin
                    e.name_main = want_main;
                    e.name_ext = want_ext;
                end
            end
            default: begin
                e.attributes = e.attributes | fdes_pkg::ATTR_LABEL;
                if ($urandom_range(0, 1) != 0) begin
                    e.name_main = want_main;
                    e.name_ext = want_ext;
                end
            end
        endcase
        return e;
    endfunction

    function automatic entry_kind_t pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return KIND_LIVE;
        if (roll < 57) return KIND_NEAR;
        if (roll < 69) return KIND_DELETED;
        if (roll < 79) return KIND_LONGNAME;
        if (roll < 87) return KIND_LABEL;
        if (roll < 93) return KIND_MATCH;
        return KIND_END;
    endfunction

    task automatic send_entry(input dir_entry_t e);
        int gap;
        bit took;
        lookup_result_t r;
        gap = draw_gap(src_idle_on);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_name_main <= e.name_main;
        s_name_ext <= e.name_ext;
        s_attributes <= e.attributes;
        s_cluster_high <= e.cluster_high;
        s_cluster_low <= e.cluster_low;
        s_sector_address <= e.sector_address;
        s_entry_index <= e.entry_index;
        s_start_search <= e.start_search;
        s_chain_end <= e.chain_end;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        entries_sent++;
        if (step_search(e, r))
            pending_lookups.push_back(r);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        bit took;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            took = pready;
            @(posedge aclk);
        end while (!took);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fdes_pkg::REG_NAME_MAIN: want_main = value;
            fdes_pkg::REG_NAME_EXT: want_ext = value[23:0];
            fdes_pkg::REG_SLOT_MODE: fresh_on_miss = value[0];
            default: ;
        endcase
        register_writes++;
        @(posedge aclk);
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_search(input int len, input bit tidy);
        dir_entry_t e;
        logic [31:0] sector;
        logic [3:0] slot;
        sector = $urandom;
        slot = 4'($urandom);
        for (int i = 0; i < len; i++) begin
            e = shape_entry(pick_kind());
            e.sector_address = sector;
            e.entry_index = slot;
            if (tidy) begin
                e.start_search = (i == 0);
                e.chain_end = (i == len - 1);
            end else begin
                e.start_search = ($urandom_range(0, 3) == 0);
                e.chain_end = ($urandom_range(0, 5) == 0);
            end
            send_entry(e);
            slot++;
            if (slot == 4'd0)
                sector++;
        end
    endtask

    task automatic test_reset_values();
        run_search(6, 1'b1);
        run_search(3, 1'b1);
        settle_block();
    endtask

    task automatic test_directed_cases();
        dir_entry_t e;
        write_register(fdes_pkg::REG_NAME_MAIN, README_MAIN);
        write_register(fdes_pkg::REG_NAME_EXT, 64'(README_EXT));
        write_register(fdes_pkg::REG_SLOT_MODE, 64'd1);
        e = entry_of(README_MAIN, README_EXT, 8'h20, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b0);
        e.cluster_high = 16'hFFFF;
        e.cluster_low = 16'hFFFF;
        send_entry(e);
        send_entry(entry_of(OTHER_MAIN, README_EXT, 8'h20, 32'd5, 4'd0, 1'b0, 1'b0));
        send_entry(entry_of(ERASED_MAIN, README_EXT, 8'h20, 32'd100, 4'd3, 1'b1, 1'b0));
        send_entry(entry_of(README_MAIN, README_EXT, fdes_pkg::ATTR_LONGNAME, 32'd100, 4'd4,
                            1'b0, 1'b0));
        send_entry(entry_of(README_MAIN, README_EXT, fdes_pkg::ATTR_LABEL, 32'd100, 4'd5,
                            1'b0, 1'b0));
        send_entry(entry_of(README_MAIN, README_EXT ^ 24'h80_0000, 8'h20, 32'd100, 4'd6,
                            1'b0, 1'b0));
        send_entry(entry_of(ERASED_MAIN, README_EXT, 8'h20, 32'd100, 4'd7, 1'b0, 1'b0));
        send_entry(entry_of(MARKER_MAIN, README_EXT, 8'h20, 32'd100, 4'd8, 1'b0, 1'b0));
        send_entry(entry_of(MARKER_MAIN, README_EXT, 8'h20, 32'd0, 4'd0, 1'b1, 1'b0));
        send_entry(entry_of(OTHER_MAIN, README_EXT, 8'hF7, 32'd9, 4'd2, 1'b1, 1'b1));
        send_entry(entry_of(ERASED_MAIN, README_EXT, 8'h20, 32'd7, 4'd15, 1'b1, 1'b1));
        send_entry(entry_of(README_MAIN, README_EXT, 8'hFF, 32'd8, 4'd1, 1'b1, 1'b1));
        send_entry(entry_of(README_MAIN, README_EXT, fdes_pkg::ATTR_LONGNAME, 32'd8, 4'd2,
                            1'b1, 1'b1));
        send_entry(entry_of(ERASED_MAIN, README_EXT, 8'h20, 32'd20, 4'd1, 1'b1, 1'b0));
        send_entry(entry_of(OTHER_MAIN, README_EXT, 8'h00, 32'd21, 4'd0, 1'b1, 1'b1));
        e = entry_of(README_MAIN, README_EXT, 8'h00, 32'd22, 4'd9, 1'b1, 1'b1);
        e.cluster_high = 16'h0000;
        e.cluster_low = 16'h0000;
        send_entry(e);
        settle_block();
        write_register(fdes_pkg::REG_SLOT_MODE, 64'd0);
        send_entry(entry_of(ERASED_MAIN, README_EXT, 8'h20, 32'd30, 4'd4, 1'b1, 1'b0));
        send_entry(entry_of(MARKER_MAIN, README_EXT, 8'h20, 32'd30, 4'd5, 1'b0, 1'b0));
        send_entry(entry_of(OTHER_MAIN, README_EXT, 8'h20, 32'd31, 4'd0, 1'b1, 1'b1));
        settle_block();
    endtask

    task automatic test_random_searches();
        int quota;
        for (int p = 0; p < 6; p++) begin
            settle_block();
            case (p)
                0: begin
                    write_register(fdes_pkg::REG_NAME_MAIN, '1);
                    write_register(fdes_pkg::REG_NAME_EXT, 64'hFF_FFFF);
                    write_register(fdes_pkg::REG_SLOT_MODE, 64'd1);
                end
                1: begin
                    write_register(fdes_pkg::REG_NAME_MAIN, '0);
                    write_register(fdes_pkg::REG_NAME_EXT, '0);
                    write_register(fdes_pkg::REG_SLOT_MODE, 64'd0);
                end
                default: begin
                    write_register(fdes_pkg::REG_NAME_MAIN, {$urandom, $urandom});
                    write_register(fdes_pkg::REG_NAME_EXT,
                                   64'($urandom_range(0, 24'hFF_FFFF)));
                    write_register(fdes_pkg::REG_SLOT_MODE, 64'(p % 2));
                end
            endcase
            quota = entries_sent + 215;
            while (entries_sent < quota)
                run_search($urandom_range(1, 20), $urandom_range(0, 9) != 0);
        end
        settle_block();
    endtask

    task automatic test_noise();
        dir_entry_t e;
        int quota;
        write_register(fdes_pkg::REG_NAME_MAIN, {$urandom, $urandom});
        write_register(fdes_pkg::REG_NAME_EXT, 64'($urandom_range(0, 24'hFF_FFFF)));
        write_register(fdes_pkg::REG_SLOT_MODE, 64'($urandom_range(0, 1)));
        quota = entries_sent + 80;
        while (entries_sent < quota) begin
            e = shape_entry(pick_kind());
            e.start_search = 1'($urandom_range(0, 1));
            e.chain_end = 1'($urandom_range(0, 1));
            send_entry(e);
        end
        settle_block();
    endtask

    initial begin
        forever begin
            int stall;
            bit took;
            stall = draw_gap(dst_idle_on);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                took = m_valid;
                @(posedge aclk);
            end while (!took);
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_lookups.size() == 0) begin
                $error("result word with nothing pending: status %0d sector %0h",
                       m_status, m_slot_sector);
                mismatches++;
            end else begin
                oldest = pending_lookups.pop_front();
                status_seen[oldest.status]++;
                if (m_status !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, m_status);
                    mismatches++;
                end
                if (m_slot_sector !== oldest.slot_sector) begin
                    $error("slot_sector: expected %0h, got %0h",
                           oldest.slot_sector, m_slot_sector);
                    mismatches++;
                end
                if (m_slot_offset !== oldest.slot_offset) begin
                    $error("slot_offset: expected %0d, got %0d",
                           oldest.slot_offset, m_slot_offset);
                    mismatches++;
                end
                if (m_start_cluster !== oldest.start_cluster) begin
                    $error("start_cluster: expected %0h, got %0h",
                           oldest.start_cluster, m_start_cluster);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #1000000;
        $display("fat_directory_entry_search regression: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_directed_cases();
        test_random_searches();
        test_noise();
        $display("scanned %0d entries, %0d inside open searches, over %0d register writes",
                 entries_sent, entries_considered, register_writes);
        $display("lookups closed: %0d existing, %0d fresh slot, %0d not found, %0d full",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("fat_directory_entry_search regression: pass");
        else
            $display("fat_directory_entry_search regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/fdes_pkg.sv
rtl/fdes_front.sv
rtl/fdes_queue.sv
rtl/fdes_back.sv
rtl/fat_directory_entry_search.sv
test/tb_top.sv
